@@ rtl/ttdv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the tilt to drive velocity block.
package ttdv_pkg;

    localparam int ANGLE_W   = 17;
    localparam int ZACC_W    = 28;
    localparam int ANG_SHIFT = 11;
    localparam int DZ_W      = 18;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = DZ_W + GAIN_W + 1;
    localparam int PROD_SHIFT = 12;
    localparam int RND_W     = PROD_W - PROD_SHIFT;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEAD_W    = 14;
    localparam int WIN_W     = 15;
    localparam int OUT_W     = 16;
    localparam int SCALE_SHIFT = 16;
    localparam int MAX_STEPS = 24;

    localparam logic signed [ZACC_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [ZACC_W-1:0] ANG_ROUND   = 28'sd1024;
    localparam logic signed [PROD_W-1:0] PROD_ROUND  = 35'sd2048;

    localparam logic signed [ZACC_W-1:0] ATAN_TAB [0:MAX_STEPS-1] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE    = 2'd0,
        REG_WINDOW_LIMIT = 2'd1,
        REG_TURN_GAIN    = 2'd2,
        REG_DRIVE_GAIN   = 2'd3
    } t_reg_idx;

    localparam logic [DEAD_W-1:0] DEAD_ZONE_RST    = 14'd819;
    localparam logic [WIN_W-1:0]  WINDOW_LIMIT_RST = 15'd10294;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST    = 16'd8192;
    localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST   = 16'd2048;

    localparam logic signed [RND_W:0] SAT_MAX = 24'sd32767;
    localparam logic signed [RND_W:0] SAT_MIN = -24'sd32768;

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [RND_W:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 16'sh7FFF;
        end else if (v < SAT_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ttdv_cordic.sv @@
`timescale 1ns / 1ps
// Unrolled vectoring CORDIC pipeline that returns atan2(y, x) in radians with 13 fraction bits.
module ttdv_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_x,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_y,
    output logic signed [ttdv_pkg::ANGLE_W-1:0]   o_angle
);

    localparam int VW = SAMPLE_WIDTH + ttdv_pkg::SCALE_SHIFT + 3;
    localparam int ZW = ttdv_pkg::ZACC_W;

    logic signed [VW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [VW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] r_zero;
    logic signed [ttdv_pkg::ANGLE_W-1:0] r_angle;

    logic signed [VW-1:0] n_xs;
    logic signed [VW-1:0] n_ys;
    logic signed [VW-1:0] n_x0;
    logic signed [VW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;
    logic signed [ZW-1:0] n_round;

    always_comb begin
        n_xs = VW'(i_x) <<< ttdv_pkg::SCALE_SHIFT;
        n_ys = VW'(i_y) <<< ttdv_pkg::SCALE_SHIFT;
        n_x0 = n_xs;
        n_y0 = n_ys;
        n_z0 = '0;
        if (n_xs[VW-1]) begin
            if (!n_ys[VW-1]) begin
                n_x0 = n_ys;
                n_y0 = -n_xs;
                n_z0 = ttdv_pkg::HALF_PI_Q24;
            end else begin
                n_x0 = -n_ys;
                n_y0 = n_xs;
                n_z0 = -ttdv_pkg::HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][VW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ttdv_pkg::ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ttdv_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    assign n_round = r_z[CORDIC_STEPS] + ttdv_pkg::ANG_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[CORDIC_STEPS]) begin
                r_angle <= '0;
            end else begin
                r_angle <= n_round[ZW-1:ttdv_pkg::ANG_SHIFT];
            end
        end
    end

    assign o_angle = r_angle;

endmodule

@@ rtl/tilt_to_drive_velocity.sv @@
`timescale 1ns / 1ps
// Top level: accelerometer tilt angles to linear and angular velocity commands.
// The block takes one sample per clock cycle while the output word is not stalled. Two unrolled
// CORDIC pipelines, one stage per iteration, form the turn and pitch angles side by side; three
// more stages apply the window check and dead zone, the gain multiply, and the rounding and
// saturation. A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
// Register writes take effect on the next cycle and should be made while no sample is in flight.
module tilt_to_drive_velocity #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [ttdv_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [ttdv_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_accel_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ttdv_pkg::OUT_W-1:0]       o_linear_velocity,
    output logic signed [ttdv_pkg::OUT_W-1:0]       o_angular_velocity,
    output logic                                    o_out_of_window
);

    localparam int LAT = CORDIC_STEPS + 5;
    localparam int DW  = ttdv_pkg::DZ_W;
    localparam int PW  = ttdv_pkg::PROD_W;
    localparam int RW  = ttdv_pkg::RND_W;

    logic [ttdv_pkg::DEAD_W-1:0] r_dead_zone;
    logic [ttdv_pkg::WIN_W-1:0]  r_window_limit;
    logic [ttdv_pkg::GAIN_W-1:0] r_turn_gain;
    logic [ttdv_pkg::GAIN_W-1:0] r_drive_gain;

    logic [LAT-1:0] r_vld;
    logic           en;

    logic signed [ttdv_pkg::ANGLE_W-1:0] turn_ang;
    logic signed [ttdv_pkg::ANGLE_W-1:0] pitch_ang;

    logic signed [DW-1:0] r_dz_t;
    logic signed [DW-1:0] r_dz_p;
    logic                 r_oow_w;
    logic signed [PW-1:0] r_prod_t;
    logic signed [PW-1:0] r_prod_p;
    logic                 r_oow_m;
    logic signed [ttdv_pkg::OUT_W-1:0] r_lin;
    logic signed [ttdv_pkg::OUT_W-1:0] r_ang;
    logic                 r_oow;

    logic signed [DW-1:0] n_t;
    logic signed [DW-1:0] n_p;
    logic signed [DW-1:0] n_d;
    logic signed [DW-1:0] n_w;
    logic                 n_in_win;
    logic signed [DW-1:0] n_dz_t;
    logic signed [DW-1:0] n_dz_p;
    logic signed [PW-1:0] n_rt;
    logic signed [PW-1:0] n_rp;
    logic signed [RW:0]   n_ang_full;
    logic signed [RW:0]   n_lin_full;

    function automatic logic signed [DW-1:0] dead(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] d);
        logic signed [DW-1:0] r;
        if (a >= d) begin
            r = a - d;
        end else if (a <= -d) begin
            r = a + d;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone    <= ttdv_pkg::DEAD_ZONE_RST;
            r_window_limit <= ttdv_pkg::WINDOW_LIMIT_RST;
            r_turn_gain    <= ttdv_pkg::TURN_GAIN_RST;
            r_drive_gain   <= ttdv_pkg::DRIVE_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (ttdv_pkg::t_reg_idx'(i_cfg_idx))
                ttdv_pkg::REG_DEAD_ZONE:    r_dead_zone    <= i_cfg_data[ttdv_pkg::DEAD_W-1:0];
                ttdv_pkg::REG_WINDOW_LIMIT: r_window_limit <= i_cfg_data[ttdv_pkg::WIN_W-1:0];
                ttdv_pkg::REG_TURN_GAIN:    r_turn_gain    <= i_cfg_data;
                ttdv_pkg::REG_DRIVE_GAIN:   r_drive_gain   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    ttdv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_turn (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (i_accel_x),
        .i_y     (i_accel_y),
        .o_angle (turn_ang)
    );

    ttdv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (i_accel_x),
        .i_y     (i_accel_z),
        .o_angle (pitch_ang)
    );

    always_comb begin
        n_t = DW'(turn_ang);
        n_p = DW'(pitch_ang);
        n_d = $signed(DW'(r_dead_zone));
        n_w = $signed(DW'(r_window_limit));
        n_in_win = (n_p < n_w) && (n_p > -n_w) && (n_t < n_w) && (n_t > -n_w);
        n_dz_t = n_in_win ? dead(n_t, n_d) : '0;
        n_dz_p = n_in_win ? dead(n_p, n_d) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dz_t   <= n_dz_t;
            r_dz_p   <= n_dz_p;
            r_oow_w  <= !n_in_win;
            r_prod_t <= r_dz_t * $signed({1'b0, r_turn_gain});
            r_prod_p <= r_dz_p * $signed({1'b0, r_drive_gain});
            r_oow_m  <= r_oow_w;
        end
    end

    always_comb begin
        n_rt = r_prod_t + ttdv_pkg::PROD_ROUND;
        n_rp = r_prod_p + ttdv_pkg::PROD_ROUND;
        n_ang_full = -((RW + 1)'($signed(n_rt[PW-1:ttdv_pkg::PROD_SHIFT])));
        n_lin_full = (RW + 1)'($signed(n_rp[PW-1:ttdv_pkg::PROD_SHIFT]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang <= ttdv_pkg::sat16(n_ang_full);
            r_lin <= ttdv_pkg::sat16(n_lin_full);
            r_oow <= r_oow_m;
        end
    end

    assign o_valid            = r_vld[LAT-1];
    assign o_linear_velocity  = r_lin;
    assign o_angular_velocity = r_ang;
    assign o_out_of_window    = r_oow;

    a_oow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_window |-> o_linear_velocity == '0 && o_angular_velocity == '0)
        else $error("Out of window word carries a nonzero velocity.");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] && i_stall |=> $stable(r_vld) && $stable(r_lin) && $stable(r_ang))
        else $error("Pipeline moved while the output word was stalled.");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled without a stalled output word.");

endmodule

@@ dv/ttdv_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for tilt_to_drive_velocity: predicts every velocity word and compares it.
module ttdv_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ttdv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttdv_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_smp_valid,
    input  logic                                i_smp_stall,
    input  logic signed [15:0]                  i_accel_x,
    input  logic signed [15:0]                  i_accel_y,
    input  logic signed [15:0]                  i_accel_z,
    input  logic                                i_vel_valid,
    input  logic                                i_vel_stall,
    input  logic signed [15:0]                  i_linear_velocity,
    input  logic signed [15:0]                  i_angular_velocity,
    input  logic                                i_out_of_window,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam longint HALF_PI_ANGLE = 64'sd26353589;

    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic               oow;
    } t_vel;

    logic [13:0] dead_zone_q;
    logic [14:0] window_q;
    logic [15:0] turn_gain_q;
    logic [15:0] drive_gain_q;
    t_vel        velocity_q[$];
    int          fails = 0;

    function automatic longint atan_step(input int i);
        case (i)
            0:  return 13176795;
            1:  return 7778716;
            2:  return 4110060;
            3:  return 2086331;
            4:  return 1047214;
            5:  return 524117;
            6:  return 262123;
            7:  return 131069;
            default: return (i < 24) ? (longint'(1) << (24 - i)) : 0;
        endcase
    endfunction

    // Vectoring rotation in Q24, result rounded to Q13 radians.
    function automatic longint tilt_angle(input longint y, input longint x);
        longint xa, ya, za, t, xs, ys;
        int i;
        if (x == 0 && y == 0) begin
            return 0;
        end
        xa = x * 65536;
        ya = y * 65536;
        za = 0;
        if (xa < 0) begin
            t = xa;
            if (ya >= 0) begin
                xa = ya;
                ya = -t;
                za = HALF_PI_ANGLE;
            end else begin
                xa = -ya;
                ya = t;
                za = -HALF_PI_ANGLE;
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya >= 0) begin
                xa = xa + ys;
                ya = ya - xs;
                za = za + atan_step(i);
            end else begin
                xa = xa - ys;
                ya = ya + xs;
                za = za - atan_step(i);
            end
        end
        return (za + 1024) >>> 11;
    endfunction

    function automatic longint dead_band(input longint a, input longint d);
        if (a >= d) begin
            return a - d;
        end
        if (a <= -d) begin
            return a + d;
        end
        return 0;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        longint c;
        c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return c[15:0];
    endfunction

    function automatic t_vel predict_velocity(input longint ax, input longint ay,
                                              input longint az);
        longint turn, pitch, w, d, tp, pp;
        t_vel r;
        turn = tilt_angle(ay, ax);
        pitch = tilt_angle(az, ax);
        w = longint'(window_q);
        d = longint'(dead_zone_q);
        r = '{lin: '0, ang: '0, oow: 1'b1};
        if (pitch < w && pitch > -w && turn < w && turn > -w) begin
            tp = dead_band(turn, d) * longint'(turn_gain_q);
            pp = dead_band(pitch, d) * longint'(drive_gain_q);
            r.ang = clamp16(-((tp + 2048) >>> 12));
            r.lin = clamp16((pp + 2048) >>> 12);
            r.oow = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : score
        t_vel want;
        if (!i_rst_n) begin
            dead_zone_q <= 14'd819;
            window_q <= 15'd10294;
            turn_gain_q <= 16'd8192;
            drive_gain_q <= 16'd2048;
            velocity_q.delete();
        end else begin
            if (i_smp_valid && !i_smp_stall) begin
                velocity_q.push_back(predict_velocity(i_accel_x, i_accel_y, i_accel_z));
            end
            if (i_vel_valid && !i_vel_stall) begin
                if (velocity_q.size() == 0) begin
                    fails++;
                    $display("%0t: velocity word arrived with none expected, got %0d %0d %0d",
                             $time, i_linear_velocity, i_angular_velocity, i_out_of_window);
                end else begin
                    want = velocity_q.pop_front();
                    if (i_linear_velocity !== want.lin) begin
                        report_mismatch("linear_velocity", want.lin, i_linear_velocity);
                    end
                    if (i_angular_velocity !== want.ang) begin
                        report_mismatch("angular_velocity", want.ang, i_angular_velocity);
                    end
                    if (i_out_of_window !== want.oow) begin
                        report_mismatch("out_of_window", want.oow, i_out_of_window);
                    end
                end
            end
            if (i_cfg_we) begin
                case (ttdv_pkg::t_reg_idx'(i_cfg_idx))
                    ttdv_pkg::REG_DEAD_ZONE:    dead_zone_q <= i_cfg_data[13:0];
                    ttdv_pkg::REG_WINDOW_LIMIT: window_q <= i_cfg_data[14:0];
                    ttdv_pkg::REG_TURN_GAIN:    turn_gain_q <= i_cfg_data;
                    ttdv_pkg::REG_DRIVE_GAIN:   drive_gain_q <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= velocity_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for tilt_to_drive_velocity: clock, reset, samples, back pressure and verdict.
module tb;

    localparam int CORDIC_STEPS   = 16;
    localparam int LATENCY        = CORDIC_STEPS + 5;
    localparam int SETTLE_CYCLES  = LATENCY + 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int NUM_SETTINGS   = 9;
    localparam int HALF_PHASE     = 46;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    ttdv_pkg::t_reg_idx                cfg_idx = ttdv_pkg::REG_DEAD_ZONE;
    logic [ttdv_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                              smp_valid = 1'b0;
    logic                              smp_stall;
    logic signed [15:0]                accel_x = '0;
    logic signed [15:0]                accel_y = '0;
    logic signed [15:0]                accel_z = '0;
    logic                              vel_valid;
    logic                              vel_stall = 1'b0;
    logic signed [ttdv_pkg::OUT_W-1:0] lin_vel;
    logic signed [ttdv_pkg::OUT_W-1:0] ang_vel;
    logic                              out_of_window;
    int                                fail_count;
    int                                pending;
    int                                tx_idle_pct = 30;
    int                                rx_idle_pct = 30;
    int                                hold_req = 0;
    int                                n_sent = 0;
    int                                n_settings = 1;
    int                                quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tilt_to_drive_velocity #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .SAMPLE_WIDTH(16)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_valid            (smp_valid),
        .o_stall            (smp_stall),
        .i_accel_x          (accel_x),
        .i_accel_y          (accel_y),
        .i_accel_z          (accel_z),
        .o_valid            (vel_valid),
        .i_stall            (vel_stall),
        .o_linear_velocity  (lin_vel),
        .o_angular_velocity (ang_vel),
        .o_out_of_window    (out_of_window)
    );

    ttdv_checker #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_smp_valid        (smp_valid),
        .i_smp_stall        (smp_stall),
        .i_accel_x          (accel_x),
        .i_accel_y          (accel_y),
        .i_accel_z          (accel_z),
        .i_vel_valid        (vel_valid),
        .i_vel_stall        (vel_stall),
        .i_linear_velocity  (lin_vel),
        .i_angular_velocity (ang_vel),
        .i_out_of_window    (out_of_window),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (smp_valid && !smp_stall) || (vel_valid && !vel_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int corner_value();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return 32767;
            4: return -32768;
            5: return 16384;
            default: return -16384;
        endcase
    endfunction

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end else if (stall_left == 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                vel_stall <= 1'b1;
                stall_left--;
            end else begin
                vel_stall <= 1'b0;
            end
        end
    end

    task automatic send_sample(input int x, input int y, input int z);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = gap_len();
        end
        if (gap > 0) begin
            smp_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp_valid <= 1'b1;
        accel_x <= 16'(x);
        accel_y <= 16'(y);
        accel_z <= 16'(z);
        do @(posedge clk); while (smp_stall);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic send_random(input int count);
        int k, kind, x, y, z, lim;
        for (k = 0; k < count; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // Mostly tilts that stay inside the window, so the gain path is exercised.
                x = $urandom_range(1, 32767);
                lim = ($urandom_range(0, 3) == 0) ? 32767 : x;
                y = int'($urandom_range(0, 2 * lim)) - lim;
                z = int'($urandom_range(0, 2 * lim)) - lim;
            end else if (kind < 85) begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end else begin
                x = corner_value();
                y = corner_value();
                z = corner_value();
            end
            send_sample(x, y, z);
        end
    endtask

    task automatic drain_results();
        smp_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
    endtask

    task automatic cfg_write(input ttdv_pkg::t_reg_idx idx, input int value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= 16'(value);
        @(negedge clk);
    endtask

    task automatic load_settings(input int dz, input int win, input int tg, input int dg);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write(ttdv_pkg::REG_DEAD_ZONE, dz);
        cfg_write(ttdv_pkg::REG_WINDOW_LIMIT, win);
        cfg_write(ttdv_pkg::REG_TURN_GAIN, tg);
        cfg_write(ttdv_pkg::REG_DRIVE_GAIN, dg);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        int p;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_sample(0, 0, 0);
        send_sample(32767, 0, 0);
        send_sample(-32768, 0, 0);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(32767, -32768, -32768);
        send_sample(32767, -32768, 32767);
        send_sample(-1, 0, 0);
        send_sample(1, 1, -1);
        send_sample(0, 1000, 0);
        send_sample(0, -1000, 5);
        send_sample(-32768, 1, -1);
        send_sample(16000, 2000, -2000);
        send_sample(16000, -2000, 2000);
        send_sample(16000, 1680, 0);
        send_sample(16000, 1610, 1610);
        send_sample(16000, 1600, -1600);
        send_sample(10000, 13000, 0);
        send_sample(10000, -30000, 0);
        send_sample(12000, 30000, 12000);

        for (p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0: load_settings(0, 25736, 65535, 65535);
                1: load_settings(8192, 25736, 4096, 4096);
                2: load_settings(16'hFFFF, 16'hFFFF, 0, 0);
                3: load_settings(0, 0, 1, 1);
                8: load_settings(819, 10294, 8192, 2048);
                default: load_settings($urandom_range(0, 8192), $urandom_range(0, 25736),
                                       $urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            if (p % 3 == 0) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = $urandom_range(10, 50);
                rx_idle_pct = $urandom_range(10, 50);
            end
            if (p == 1) begin
                // Hold the output side long enough for the pipeline to fill and push back.
                tx_idle_pct = 0;
                hold_req = HOLD_CYCLES;
            end
            send_random(HALF_PHASE);
            drain_results();
            if (p == 1) begin
                tx_idle_pct = 30;
            end
            send_random(HALF_PHASE);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d samples under %0d register settings, with an output hold-off",
                 n_sent, n_settings);
        $display("and drained pauses; %0d mismatches were seen.", fail_count);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
